// ----- rtl/core/pbfl_pkg.sv -----
// ----------------------------------------------------------------------------
// pbfl_pkg
// Shared types, widths and codes of the page bucket free list allocator.
// ----------------------------------------------------------------------------
package pbfl_pkg;

	localparam int unsigned DEF_MAX_SEGMENTS = 256;
	localparam int unsigned DEF_NUM_BUCKETS  = 128 / 4 + 1;
	localparam int unsigned DEF_MAX_PAGES    = 1048576;

	localparam int unsigned START_W = 20;
	localparam int unsigned LEN_W   = 21;
	localparam int unsigned PAGES_W = 24;
	localparam int unsigned END_W   = 25;
	localparam int unsigned ENT_W   = 1 + LEN_W + START_W;

	localparam logic [4:0] SHIFT_MIN   = 5'd9;
	localparam logic [4:0] SHIFT_MAX   = 5'd16;
	localparam logic [4:0] SHIFT_RESET = 5'd12;

	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_ADD    = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [2:0] STAT_OK      = 3'd0;
	localparam logic [2:0] STAT_NOFIT   = 3'd1;
	localparam logic [2:0] STAT_BADFREE = 3'd2;
	localparam logic [2:0] STAT_FULL    = 3'd3;
	localparam logic [2:0] STAT_RANGE   = 3'd4;

	typedef struct packed {
		logic               hit;
		logic [LEN_W-1:0]   len;
		logic [START_W-1:0] start;
	} cand_t;

	typedef struct packed {
		logic               busy;
		logic [LEN_W-1:0]   len;
		logic [START_W-1:0] start;
	} entry_t;

endpackage

// ----- rtl/core/pbfl_ram.sv -----
// ----------------------------------------------------------------------------
// pbfl_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pbfl_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/pbfl_scan.sv -----
// ----------------------------------------------------------------------------
// pbfl_scan
// Shared compare unit: looks at one segment entry per cycle and keeps the
// best fit, the busy block at the key offset, the neighbours, overlap and the first empty slot.
// ----------------------------------------------------------------------------
module pbfl_scan #(
	parameter int unsigned IW          = 8,
	parameter int unsigned NUM_BUCKETS = pbfl_pkg::DEF_NUM_BUCKETS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          clear,
	input  logic                          ent_vld,
	input  logic                          ent_used,
	input  logic [IW-1:0]                 ent_idx,
	input  pbfl_pkg::entry_t              ent,
	input  logic [pbfl_pkg::PAGES_W-1:0]  pages,
	input  logic [pbfl_pkg::START_W-1:0]  key_off,
	input  logic [pbfl_pkg::END_W-1:0]    key_end,
	output pbfl_pkg::cand_t               snug,
	output logic [IW-1:0]                 snug_idx,
	output pbfl_pkg::cand_t               big,
	output logic [IW-1:0]                 big_idx,
	output pbfl_pkg::cand_t               blk,
	output logic [IW-1:0]                 blk_idx,
	output pbfl_pkg::cand_t               pv,
	output logic [IW-1:0]                 pv_idx,
	output pbfl_pkg::cand_t               nx,
	output logic [IW-1:0]                 nx_idx,
	output logic                          overlap,
	output logic                          empty_hit,
	output logic [IW-1:0]                 empty_idx
);

	localparam logic [pbfl_pkg::LEN_W-1:0] BIG = pbfl_pkg::LEN_W'(NUM_BUCKETS - 1);

	pbfl_pkg::cand_t snug_q, big_q, blk_q, pv_q, nx_q;
	logic [IW-1:0] snug_idx_q, big_idx_q, blk_idx_q, pv_idx_q, nx_idx_q, empty_idx_q;
	logic overlap_q, empty_hit_q;

	logic [pbfl_pkg::LEN_W:0]     ent_end;
	logic [pbfl_pkg::PAGES_W-1:0] ent_len_x;
	logic [pbfl_pkg::END_W-1:0]   ent_start_x;
	logic fits, is_free;

	assign ent_end     = {1'b0, ent.len} + {2'b0, ent.start};
	assign ent_len_x   = {3'b0, ent.len};
	assign ent_start_x = {5'b0, ent.start};
	assign fits        = ent_len_x >= pages;
	assign is_free     = !ent.busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snug_q      <= '0;
			big_q       <= '0;
			blk_q       <= '0;
			pv_q        <= '0;
			nx_q        <= '0;
			overlap_q   <= 1'b0;
			empty_hit_q <= 1'b0;
		end else if (clear) begin
			snug_q.hit  <= 1'b0;
			big_q.hit   <= 1'b0;
			blk_q.hit   <= 1'b0;
			pv_q.hit    <= 1'b0;
			nx_q.hit    <= 1'b0;
			overlap_q   <= 1'b0;
			empty_hit_q <= 1'b0;
		end else if (ent_vld) begin
			if (!ent_used) begin
				if (!empty_hit_q) begin
					empty_hit_q <= 1'b1;
					empty_idx_q <= ent_idx;
				end
			end else begin
				if (is_free && ent.len < BIG && fits && (!snug_q.hit || ent.len < snug_q.len
						|| (ent.len == snug_q.len && ent.start < snug_q.start))) begin
					snug_q     <= '{hit: 1'b1, len: ent.len, start: ent.start};
					snug_idx_q <= ent_idx;
				end
				if (is_free && ent.len >= BIG && fits
						&& (!big_q.hit || ent.start < big_q.start)) begin
					big_q     <= '{hit: 1'b1, len: ent.len, start: ent.start};
					big_idx_q <= ent_idx;
				end
				if (ent.busy && ent.start == key_off && !blk_q.hit) begin
					blk_q     <= '{hit: 1'b1, len: ent.len, start: ent.start};
					blk_idx_q <= ent_idx;
				end
				if (is_free && ent_end == {2'b0, key_off} && !pv_q.hit) begin
					pv_q     <= '{hit: 1'b1, len: ent.len, start: ent.start};
					pv_idx_q <= ent_idx;
				end
				if (is_free && ent_start_x == key_end && !nx_q.hit) begin
					nx_q     <= '{hit: 1'b1, len: ent.len, start: ent.start};
					nx_idx_q <= ent_idx;
				end
				if (ent_start_x < key_end && {2'b0, key_off} < ent_end) begin
					overlap_q <= 1'b1;
				end
			end
		end
	end

	assign snug      = snug_q;
	assign snug_idx  = snug_idx_q;
	assign big       = big_q;
	assign big_idx   = big_idx_q;
	assign blk       = blk_q;
	assign blk_idx   = blk_idx_q;
	assign pv        = pv_q;
	assign pv_idx    = pv_idx_q;
	assign nx        = nx_q;
	assign nx_idx    = nx_idx_q;
	assign overlap   = overlap_q;
	assign empty_hit = empty_hit_q;
	assign empty_idx = empty_idx_q;

endmodule

// ----- rtl/core/page_bucket_free_list_allocator_core.sv -----
// ----------------------------------------------------------------------------
// page_bucket_free_list_allocator_core
// Page granular allocator over a segment table with size bucket best fit.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready) carries kind, req_bytes and
//   block_offset; one beat per operation. Response channel
//   (rsp_valid/rsp_ready) returns one beat with status, granted_offset,
//   granted_pages and free_pages for each request, in order.
//   cfg_we/cfg_data write page_shift; write it only while idle.
// Timing:
//   One request is handled at a time; req_ready is high only when idle.
//   Each pass reads the segment RAM one entry per cycle through the shared
//   compare unit. Alloc and add take one pass and free takes two when the
//   block is found; a split alloc adds a second write in ST_WR2 before
//   ST_DONE raises the response. The next request can be taken in the same
//   cycle as the response is raised. Zero byte allocs, bad regions and
//   unused kinds go from ST_IDLE straight to ST_DONE without a scan.
// Reset:
//   arst_n clears all valid bits and the free page count; page_shift
//   returns to 12. No clearing pass is needed.
// Stall:
//   A finished response waits in the output register; the sequencer holds
//   until rsp_ready takes the pending beat.
// ----------------------------------------------------------------------------
module page_bucket_free_list_allocator_core #(
	parameter int unsigned MAX_SEGMENTS = pbfl_pkg::DEF_MAX_SEGMENTS,
	parameter int unsigned NUM_BUCKETS  = pbfl_pkg::DEF_NUM_BUCKETS,
	parameter int unsigned MAX_PAGES    = pbfl_pkg::DEF_MAX_PAGES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] req_bytes,
	input  logic [19:0] block_offset,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [2:0]  status,
	output logic [19:0] granted_offset,
	output logic [20:0] granted_pages,
	output logic [20:0] free_pages
);

	localparam int unsigned IW = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [CW-1:0] CNT_END = CW'(MAX_SEGMENTS);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_SCAN  = 5'b00010,
		ST_SCAN2 = 5'b00100,
		ST_WR2   = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q;
	logic [4:0] page_shift_q;
	logic [MAX_SEGMENTS-1:0] valid_q;
	logic [CW-1:0] cnt_q;
	logic vld_s1;
	logic [IW-1:0] idx_s1;

	logic [1:0]  kind_q;
	logic [19:0] off_q;
	logic [pbfl_pkg::PAGES_W-1:0] pages_q;
	logic [pbfl_pkg::END_W-1:0]   end_q;
	logic [IW-1:0] blk_idx_q;
	logic [20:0] blk_len_q;
	logic [20:0] free_q;

	logic wr_en_q;
	logic [IW-1:0] wr_addr_q;
	pbfl_pkg::entry_t wr_data_q;
	logic [IW-1:0] split_idx_q;
	pbfl_pkg::entry_t split_data_q;

	logic [2:0]  res_status_q;
	logic [19:0] res_off_q;
	logic [20:0] res_pages_q;

	logic        rsp_valid_q;
	logic [2:0]  status_q;
	logic [19:0] granted_offset_q;
	logic [20:0] granted_pages_q;
	logic [20:0] free_pages_q;

	logic [pbfl_pkg::ENT_W-1:0] rd_word;
	pbfl_pkg::entry_t rd_ent;

	pbfl_pkg::cand_t snug, big, blk, pv, nx, ch;
	logic [IW-1:0] snug_idx, big_idx, blk_idx, pv_idx, nx_idx, empty_idx, ch_idx;
	logic overlap, empty_hit;

	logic [4:0]  sh;
	logic [31:0] mask;
	logic [32:0] round_sum;
	logic [pbfl_pkg::PAGES_W-1:0] alloc_pages, add_pages;
	logic [pbfl_pkg::END_W-1:0]   add_end;
	logic add_bad, accept, scan_done, scan_clr;
	logic [20:0] pages21, free_len, add_nx_len;

	assign sh = (page_shift_q < pbfl_pkg::SHIFT_MIN) ? pbfl_pkg::SHIFT_MIN :
		(page_shift_q > pbfl_pkg::SHIFT_MAX) ? pbfl_pkg::SHIFT_MAX : page_shift_q;
	assign mask        = (32'd1 << sh) - 32'd1;
	assign round_sum   = {1'b0, req_bytes} + {1'b0, mask};
	assign alloc_pages = pbfl_pkg::PAGES_W'(round_sum >> sh);
	assign add_pages   = pbfl_pkg::PAGES_W'(req_bytes >> sh);
	assign add_end     = {5'b0, block_offset} + {1'b0, add_pages};
	assign add_bad     = ((req_bytes & mask) != 32'd0) || (add_pages == '0)
		|| ({1'b0, add_end} > 26'(MAX_PAGES));

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign scan_done = (cnt_q == CNT_END) && !vld_s1;
	assign scan_clr  = (state_q == ST_IDLE)
		|| (state_q == ST_SCAN && scan_done && kind_q == pbfl_pkg::KIND_FREE);

	assign rd_ent = pbfl_pkg::entry_t'(rd_word);

	assign ch     = snug.hit ? snug : big;
	assign ch_idx = snug.hit ? snug_idx : big_idx;

	assign pages21    = pages_q[20:0];
	assign free_len   = blk_len_q + (nx.hit ? nx.len : 21'd0);
	assign add_nx_len = pages21 + (nx.hit ? nx.len : 21'd0);

	pbfl_ram #(
		.WIDTH(pbfl_pkg::ENT_W),
		.DEPTH(MAX_SEGMENTS)
	) u_seg_ram (
		.clk  (clk),
		.we   (wr_en_q),
		.waddr(wr_addr_q),
		.wdata(wr_data_q),
		.raddr(cnt_q[IW-1:0]),
		.rdata(rd_word)
	);

	pbfl_scan #(
		.IW         (IW),
		.NUM_BUCKETS(NUM_BUCKETS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.clear    (scan_clr),
		.ent_vld  (vld_s1),
		.ent_used (valid_q[idx_s1]),
		.ent_idx  (idx_s1),
		.ent      (rd_ent),
		.pages    (pages_q),
		.key_off  (off_q),
		.key_end  (end_q),
		.snug     (snug),
		.snug_idx (snug_idx),
		.big      (big),
		.big_idx  (big_idx),
		.blk      (blk),
		.blk_idx  (blk_idx),
		.pv       (pv),
		.pv_idx   (pv_idx),
		.nx       (nx),
		.nx_idx   (nx_idx),
		.overlap  (overlap),
		.empty_hit(empty_hit),
		.empty_idx(empty_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_shift_q <= pbfl_pkg::SHIFT_RESET;
		end else if (cfg_we) begin
			page_shift_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (scan_clr) begin
				cnt_q <= '0;
			end else if ((state_q == ST_SCAN || state_q == ST_SCAN2) && cnt_q != CNT_END) begin
				cnt_q <= cnt_q + CW'(1);
			end
			vld_s1 <= (state_q == ST_SCAN || state_q == ST_SCAN2) && !scan_clr
				&& cnt_q != CNT_END;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= cnt_q[IW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			valid_q      <= '0;
			free_q       <= '0;
			wr_en_q      <= 1'b0;
			rsp_valid_q  <= 1'b0;
			res_status_q <= pbfl_pkg::STAT_OK;
		end else begin
			wr_en_q <= 1'b0;
			if (rsp_valid_q && rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						kind_q       <= kind;
						off_q        <= block_offset;
						pages_q      <= (kind == pbfl_pkg::KIND_ALLOC) ? alloc_pages : add_pages;
						end_q        <= add_end;
						res_off_q    <= '0;
						res_pages_q  <= '0;
						res_status_q <= pbfl_pkg::STAT_OK;
						state_q      <= ST_SCAN;
						case (kind)
							pbfl_pkg::KIND_ALLOC: begin
								if (req_bytes == 32'd0) begin
									res_status_q <= pbfl_pkg::STAT_NOFIT;
									state_q      <= ST_DONE;
								end
							end
							pbfl_pkg::KIND_FREE: begin
							end
							pbfl_pkg::KIND_ADD: begin
								if (add_bad) begin
									res_status_q <= pbfl_pkg::STAT_RANGE;
									state_q      <= ST_DONE;
								end
							end
							default: begin
								res_status_q <= pbfl_pkg::STAT_RANGE;
								state_q      <= ST_DONE;
							end
						endcase
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_DONE;
						case (kind_q)
							pbfl_pkg::KIND_ALLOC: begin
								if (!ch.hit) begin
									res_status_q <= pbfl_pkg::STAT_NOFIT;
								end else if ({3'b0, ch.len} == pages_q) begin
									wr_en_q     <= 1'b1;
									wr_addr_q   <= ch_idx;
									wr_data_q   <= '{busy: 1'b1, len: ch.len, start: ch.start};
									res_off_q   <= ch.start;
									res_pages_q <= pages21;
									free_q      <= free_q - pages21;
								end else if (!empty_hit) begin
									res_status_q <= pbfl_pkg::STAT_FULL;
								end else begin
									wr_en_q            <= 1'b1;
									wr_addr_q          <= empty_idx;
									wr_data_q          <= '{busy: 1'b1, len: pages21, start: ch.start};
									valid_q[empty_idx] <= 1'b1;
									split_idx_q        <= ch_idx;
									split_data_q       <= '{busy: 1'b0, len: ch.len - pages21,
										start: ch.start + pages_q[19:0]};
									res_off_q          <= ch.start;
									res_pages_q        <= pages21;
									free_q             <= free_q - pages21;
									state_q            <= ST_WR2;
								end
							end
							pbfl_pkg::KIND_FREE: begin
								if (!blk.hit) begin
									res_status_q <= pbfl_pkg::STAT_BADFREE;
								end else begin
									blk_idx_q <= blk_idx;
									blk_len_q <= blk.len;
									end_q     <= {5'b0, off_q} + {4'b0, blk.len};
									state_q   <= ST_SCAN2;
								end
							end
							default: begin
								if (overlap) begin
									res_status_q <= pbfl_pkg::STAT_RANGE;
								end else if (pv.hit) begin
									wr_en_q   <= 1'b1;
									wr_addr_q <= pv_idx;
									wr_data_q <= '{busy: 1'b0, len: pv.len + add_nx_len,
										start: pv.start};
									if (nx.hit) begin
										valid_q[nx_idx] <= 1'b0;
									end
									free_q <= free_q + pages21;
								end else if (nx.hit) begin
									wr_en_q   <= 1'b1;
									wr_addr_q <= nx_idx;
									wr_data_q <= '{busy: 1'b0, len: add_nx_len, start: off_q};
									free_q    <= free_q + pages21;
								end else if (empty_hit) begin
									wr_en_q            <= 1'b1;
									wr_addr_q          <= empty_idx;
									wr_data_q          <= '{busy: 1'b0, len: pages21, start: off_q};
									valid_q[empty_idx] <= 1'b1;
									free_q             <= free_q + pages21;
								end else begin
									res_status_q <= pbfl_pkg::STAT_FULL;
								end
							end
						endcase
					end
				end
				ST_SCAN2: begin
					if (scan_done) begin
						free_q <= free_q + blk_len_q;
						if (nx.hit) begin
							valid_q[nx_idx] <= 1'b0;
						end
						wr_en_q <= 1'b1;
						if (pv.hit) begin
							wr_addr_q          <= pv_idx;
							wr_data_q          <= '{busy: 1'b0, len: pv.len + free_len,
								start: pv.start};
							valid_q[blk_idx_q] <= 1'b0;
						end else begin
							wr_addr_q <= blk_idx_q;
							wr_data_q <= '{busy: 1'b0, len: free_len, start: off_q};
						end
						state_q <= ST_DONE;
					end
				end
				ST_WR2: begin
					wr_en_q   <= 1'b1;
					wr_addr_q <= split_idx_q;
					wr_data_q <= split_data_q;
					state_q   <= ST_DONE;
				end
				ST_DONE: begin
					if (!rsp_valid_q || rsp_ready) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!rsp_valid_q || rsp_ready)) begin
			status_q         <= res_status_q;
			granted_offset_q <= res_off_q;
			granted_pages_q  <= res_pages_q;
			free_pages_q     <= free_q;
		end
	end

	assign rsp_valid      = rsp_valid_q;
	assign status         = status_q;
	assign granted_offset = granted_offset_q;
	assign granted_pages  = granted_pages_q;
	assign free_pages     = free_pages_q;

`ifndef ASSERT_OFF
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en_q)
		else $error("segment write pending while idle");

	a_free_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{11'b0, free_q} <= 32'(MAX_PAGES))
		else $error("free page count beyond store size");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_END)
		else $error("scan counter overrun");

	a_done_write: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WR2 |=> wr_en_q && state_q == ST_DONE)
		else $error("split write not issued");
`endif

endmodule

// ----- dv/page_alloc_scoreboard.sv -----
// ----------------------------------------------------------------------------
// page_alloc_scoreboard
// Watches the request, response and page_shift ports of the page allocator,
// keeps its own segment table to work out each expected response beat, and
// compares every response field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module page_alloc_scoreboard
	import pbfl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_data,
	input  logic        req_valid,
	input  logic        req_ready,
	input  logic [1:0]  kind,
	input  logic [31:0] req_bytes,
	input  logic [19:0] block_offset,
	input  logic        rsp_valid,
	input  logic        rsp_ready,
	input  logic [2:0]  status,
	input  logic [19:0] granted_offset,
	input  logic [20:0] granted_pages,
	input  logic [20:0] free_pages,
	output int          errors,
	output int          pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SEGS = DEF_MAX_SEGMENTS;
	localparam longint BIG = DEF_NUM_BUCKETS - 1;

	typedef struct packed {
		logic [2:0]  st;
		logic [19:0] off;
		logic [20:0] pg;
		logic [20:0] fr;
	} outcome_t;

	bit                 used[SEGS];
	bit                 taken[SEGS];
	logic [19:0]        base[SEGS];
	logic [20:0]        span[SEGS];
	logic [20:0]        free_total;
	logic [4:0]         shift_reg;
	outcome_t           outcome_q[$];

	function automatic int eff_shift();
		if (shift_reg < SHIFT_MIN) return SHIFT_MIN;
		if (shift_reg > SHIFT_MAX) return SHIFT_MAX;
		return shift_reg;
	endfunction

	function automatic int spare_slot();
		for (int i = 0; i < SEGS; i++) if (!used[i]) return i;
		return -1;
	endfunction

	function automatic int free_ending(longint at);
		for (int i = 0; i < SEGS; i++)
			if (used[i] && !taken[i] && longint'(base[i]) + span[i] == at) return i;
		return -1;
	endfunction

	function automatic int free_starting(longint at);
		for (int i = 0; i < SEGS; i++)
			if (used[i] && !taken[i] && longint'(base[i]) == at) return i;
		return -1;
	endfunction

	function automatic logic [2:0] carve(longint bytes, output logic [19:0] goff,
			output logic [20:0] gpg);
		int sh;
		longint pages;
		int best;
		int slot;
		sh = eff_shift();
		best = -1;
		goff = '0;
		gpg = '0;
		if (bytes == 0) return STAT_NOFIT;
		pages = (bytes + (longint'(1) << sh) - 1) >> sh;
		for (int i = 0; i < SEGS; i++) begin
			if (!used[i] || taken[i] || span[i] >= BIG || span[i] < pages) continue;
			if (best < 0 || span[i] < span[best] ||
					(span[i] == span[best] && base[i] < base[best]))
				best = i;
		end
		if (best < 0)
			for (int i = 0; i < SEGS; i++) begin
				if (!used[i] || taken[i] || span[i] < BIG || span[i] < pages) continue;
				if (best < 0 || base[i] < base[best]) best = i;
			end
		if (best < 0) return STAT_NOFIT;
		if (longint'(span[best]) != pages) begin
			slot = spare_slot();
			if (slot < 0) return STAT_FULL;
			used[slot] = 1;
			taken[slot] = 1;
			base[slot] = base[best];
			span[slot] = pages[20:0];
			base[best] = base[best] + pages[19:0];
			span[best] = span[best] - pages[20:0];
			goff = base[slot];
		end else begin
			taken[best] = 1;
			goff = base[best];
		end
		gpg = pages[20:0];
		free_total = free_total - pages[20:0];
		return STAT_OK;
	endfunction

	function automatic logic [2:0] release_block(logic [19:0] off);
		int blk;
		int nx;
		int pv;
		blk = -1;
		for (int i = 0; i < SEGS; i++)
			if (used[i] && taken[i] && base[i] == off) begin
				blk = i;
				break;
			end
		if (blk < 0) return STAT_BADFREE;
		taken[blk] = 0;
		free_total = free_total + span[blk];
		nx = free_starting(longint'(base[blk]) + span[blk]);
		if (nx >= 0 && nx != blk) begin
			span[blk] = span[blk] + span[nx];
			used[nx] = 0;
		end
		pv = free_ending(base[blk]);
		if (pv >= 0 && pv != blk) begin
			span[pv] = span[pv] + span[blk];
			used[blk] = 0;
		end
		return STAT_OK;
	endfunction

	function automatic logic [2:0] add_region(longint bytes, logic [19:0] off);
		int sh;
		longint pages;
		longint fin;
		int pv;
		int nx;
		int slot;
		sh = eff_shift();
		if ((bytes & ((longint'(1) << sh) - 1)) != 0) return STAT_RANGE;
		pages = bytes >> sh;
		fin = longint'(off) + pages;
		if (pages == 0 || fin > DEF_MAX_PAGES) return STAT_RANGE;
		for (int i = 0; i < SEGS; i++)
			if (used[i] && longint'(base[i]) < fin && longint'(off) < longint'(base[i]) + span[i])
				return STAT_RANGE;
		pv = free_ending(off);
		nx = free_starting(fin);
		if (pv >= 0) begin
			span[pv] = span[pv] + pages[20:0];
			if (nx >= 0) begin
				span[pv] = span[pv] + span[nx];
				used[nx] = 0;
			end
		end else if (nx >= 0) begin
			base[nx] = off;
			span[nx] = span[nx] + pages[20:0];
		end else begin
			slot = spare_slot();
			if (slot < 0) return STAT_FULL;
			used[slot] = 1;
			taken[slot] = 0;
			base[slot] = off;
			span[slot] = pages[20:0];
		end
		free_total = free_total + pages[20:0];
		return STAT_OK;
	endfunction

	function automatic outcome_t predict_beat(logic [1:0] k, logic [31:0] b, logic [19:0] o);
		outcome_t r;
		r = '0;
		case (k)
			KIND_ALLOC: r.st = carve(b, r.off, r.pg);
			KIND_FREE: r.st = release_block(o);
			KIND_ADD: r.st = add_region(b, o);
			default: r.st = STAT_RANGE;
		endcase
		if (r.st != STAT_OK) begin
			r.off = '0;
			r.pg = '0;
		end
		r.fr = free_total;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < SEGS; i++) used[i] = 0;
			free_total = '0;
			shift_reg = SHIFT_RESET;
			outcome_q.delete();
			errors = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (outcome_q.size() == 0) begin
					$error("response beat with no expectation waiting");
					errors++;
				end else begin
					want = outcome_q.pop_front();
					if (status !== want.st) begin
						$error("status expected %0d actual %0d", want.st, status);
						errors++;
					end
					if (granted_offset !== want.off) begin
						$error("granted_offset expected %0d actual %0d", want.off, granted_offset);
						errors++;
					end
					if (granted_pages !== want.pg) begin
						$error("granted_pages expected %0d actual %0d", want.pg, granted_pages);
						errors++;
					end
					if (free_pages !== want.fr) begin
						$error("free_pages expected %0d actual %0d", want.fr, free_pages);
						errors++;
					end
				end
			end
			if (cfg_we) shift_reg = cfg_data;
			if (req_valid && req_ready)
				outcome_q.push_back(predict_beat(kind, req_bytes, block_offset));
		end
		pending = outcome_q.size();
	end

endmodule

// ----- dv/page_bucket_free_list_allocator_core_test.sv -----
// ----------------------------------------------------------------------------
// page_bucket_free_list_allocator_core_test
// Drives directed and random allocate, free and add-region beats across
// several page sizes with random gaps and response stalls; the scoreboard
// predicts and checks every response.
// ----------------------------------------------------------------------------
module page_bucket_free_list_allocator_core_test;
	import pbfl_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        cfg_we = 0;
	logic [4:0]  cfg_data = '0;
	logic        req_valid = 0;
	logic        req_ready;
	logic [1:0]  kind = '0;
	logic [31:0] req_bytes = '0;
	logic [19:0] block_offset = '0;
	logic        rsp_valid;
	logic        rsp_ready = 0;
	logic [2:0]  status;
	logic [19:0] granted_offset;
	logic [20:0] granted_pages;
	logic [20:0] free_pages;
	int          errors;
	int          pending;
	int          cycles = 0;
	int          rsp_hold = 0;
	bit          calm = 0;
	int          cur_shift = SHIFT_RESET;
	int          cursor = 2000;
	int          grant_q[$];

	always #2 clk = ~clk;

	page_bucket_free_list_allocator_core dut (.*);

	page_alloc_scoreboard sb (.*);

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 40) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 20);
		return $urandom_range(50, 300);
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (cycles > 3000000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (rsp_valid && rsp_ready && status == STAT_OK && granted_pages != 0)
			grant_q.push_back(granted_offset);
		if (rsp_hold > 0) begin
			rsp_hold--;
		end else if (calm || $urandom_range(0, 99) < 70) begin
			rsp_ready <= 1;
			rsp_hold = $urandom_range(0, 10);
		end else begin
			rsp_ready <= 0;
			rsp_hold = pick_gap();
		end
	end

	task automatic send(logic [1:0] k, logic [31:0] b, logic [19:0] o);
		int gap;
		req_valid <= 1;
		kind <= k;
		req_bytes <= b;
		block_offset <= o;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_shift(int sh);
		drain();
		cfg_we <= 1;
		cfg_data <= sh[4:0];
		@(posedge clk);
		cfg_we <= 0;
		cur_shift = sh < SHIFT_MIN ? SHIFT_MIN : (sh > SHIFT_MAX ? SHIFT_MAX : sh);
		@(posedge clk);
	endtask

	task automatic random_beat(int alloc_pct, int free_pct, int add_pct, bit fill);
		int r;
		int n;
		int idx;
		longint page;
		page = longint'(1) << cur_shift;
		r = $urandom_range(0, 99);
		if (r < alloc_pct) begin
			n = fill ? $urandom_range(1, 4) :
				($urandom_range(0, 9) < 8 ? $urandom_range(1, 40) : $urandom_range(41, 300));
			case ($urandom_range(0, 19))
				0: send(KIND_ALLOC, 32'd0, 20'($urandom));
				1: send(KIND_ALLOC, $urandom, 20'($urandom));
				default: send(KIND_ALLOC, 32'(n * page - $urandom_range(0, page - 1)),
					20'($urandom));
			endcase
		end else if (r < alloc_pct + free_pct) begin
			if (grant_q.size() > 0 && $urandom_range(0, 9) < 8) begin
				idx = $urandom_range(0, grant_q.size() - 1);
				send(KIND_FREE, $urandom, 20'(grant_q[idx]));
				grant_q.delete(idx);
			end else begin
				send(KIND_FREE, $urandom,
					20'($urandom_range(0, 3) == 0 ? $urandom : cursor / 2));
			end
		end else if (r < alloc_pct + free_pct + add_pct) begin
			n = fill ? $urandom_range(100, 400) :
				($urandom_range(0, 9) < 9 ? $urandom_range(1, 64) : $urandom_range(200, 2000));
			case ($urandom_range(0, 9))
				0: send(KIND_ADD, 32'(n * page), 20'($urandom_range(0, cursor)));
				1: send(KIND_ADD, 32'(n * page + $urandom_range(1, page - 1)), 20'(cursor + 10));
				2: send(KIND_ADD, 32'(n * page), 20'(DEF_MAX_PAGES - n + 1));
				default: begin
					if (fill || $urandom_range(0, 1)) cursor += $urandom_range(1, 8);
					send(KIND_ADD, 32'(n * page), 20'(cursor));
					cursor += n;
				end
			endcase
		end else begin
			send(KIND_UNUSED, $urandom, 20'($urandom));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		calm = 1;
		send(KIND_ALLOC, 32'd0, 20'd0);
		send(KIND_ALLOC, 32'd1, 20'hFFFFF);
		send(KIND_ADD, 32'd40 * 4096, 20'd1000);
		send(KIND_ADD, 32'd5 * 4096, 20'd1050);
		send(KIND_ADD, 32'd5 * 4096, 20'd1045);
		send(KIND_ADD, 32'd5 * 4096, 20'd1040);
		send(KIND_ADD, 32'd4097, 20'd3000);
		send(KIND_ADD, 32'd0, 20'd3000);
		send(KIND_ADD, 32'd10 * 4096, 20'd1048570);
		send(KIND_ADD, 32'd10 * 4096, 20'd1048566);
		send(KIND_ADD, 32'd4 * 4096, 20'd1010);
		send(KIND_UNUSED, 32'hFFFFFFFF, 20'hFFFFF);
		send(KIND_ALLOC, 32'd1, 20'd0);
		send(KIND_ALLOC, 32'd9 * 4096, 20'd0);
		send(KIND_ALLOC, 32'd33 * 4096, 20'd0);
		send(KIND_ALLOC, 32'hFFFFFFFF, 20'd0);
		send(KIND_FREE, 32'd0, 20'd1048567);
		send(KIND_FREE, 32'd0, 20'd1048567);
		send(KIND_FREE, 32'd0, 20'd1000);
		send(KIND_FREE, 32'd0, 20'd1048566);
		send(KIND_FREE, 32'hFFFFFFFF, 20'hFFFFF);
		calm = 0;
		drain();
		grant_q.delete();

		repeat (100) random_beat(45, 30, 20, 0);
		set_shift(9);
		repeat (250) random_beat(80, 5, 15, 1);
		set_shift(16);
		repeat (60) random_beat(35, 45, 15, 0);
		set_shift(0);
		calm = 1;
		repeat (60) random_beat(40, 40, 15, 0);
		calm = 0;
		set_shift(31);
		repeat (90) random_beat(45, 30, 20, 0);
		set_shift(13);
		repeat (70) random_beat(45, 30, 20, 0);

		drain();
		repeat (600) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
